>>> design/rcat_pkg.sv
// Shared types and constants for the RGBA cell average/threshold block.
// Used by the top level, the result queue and the port checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcat_pkg;

  // Cell geometry and threshold
  localparam int CELL_W = 5;
  localparam int CELL_H = 10;
  localparam int THRESH = 128;

  // Field widths
  localparam int PIX_W     = 8;
  localparam int SUM_W     = 14;  // 50 pixels * 255 fits in 14 bits
  localparam int COORD_W   = 9;
  localparam int COLOR_W   = 3;
  localparam int SUB_W     = 3;   // column inside a cell, 0..4
  localparam int RIN_W     = 4;   // row inside a cell, 0..9
  localparam int CNT_W     = 6;   // pixels in a cell, up to 50
  localparam int LIM_W     = 13;  // 129 * 50
  localparam int FW_W      = 12;
  localparam int FH_W      = 13;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int IN_DW     = 32;
  localparam int OUT_DW    = 24;

  // Reset values of the configuration registers
  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  // floor(x / 5) = (x * DIV5_MUL) >> DIV5_SH, exact for x below 2^18
  localparam logic [31:0] DIV5_MUL = 32'd52429;
  localparam int          DIV5_SH  = 18;

  // Result queue depth
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  // Configuration register index (byte address bits [3:2])
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_FLIP_ROWS    = 2'd2
  } cfg_reg_t;

  typedef logic [3:0][SUM_W-1:0] sum_vec_t;
  typedef logic [3:0][PIX_W-1:0] pix_vec_t;

  typedef struct packed {
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
    logic [COLOR_W-1:0] color;
    logic               opaque;
    logic               row_end;
  } result_t;

endpackage : rcat_pkg

`default_nettype wire

>>> design/rcat_out_fifo.sv
// Result queue between the accumulator pipeline and the output channel.
// Small register FIFO; depends on rcat_pkg for the result type and depth.
`timescale 1ns / 1ps
`default_nettype none

module rcat_out_fifo
  import rcat_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire result_t              push_data,
  input  wire logic                 pop_ready,
  output logic                      pop_valid,
  output result_t                   pop_data,
  output logic [OUT_CNT_W-1:0]      count
);

  result_t                slot_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OUT_CNT_W-1:0]   count_r, count_nxt;
  logic                   pop;

  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign count     = count_r;
  assign pop       = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : rcat_out_fifo

`default_nettype wire

>>> design/rgba_cell_average_threshold_top.sv
// Top level of the RGBA cell average/threshold block: config registers,
// position tracking, cell-sum memory with read-modify-write, result queue.
// Depends on rcat_pkg and rcat_out_fifo.
//
// Usage:
//   in_*  : one RGBA8 pixel per transaction, memory raster order.
//   out_* : one transaction per completed cell (5 x 10 pixels, fewer at the
//           right and bottom edges); tlast marks the rightmost cell of a row.
//   cfg_* : APB registers frame_width (0x0), frame_height (0x4),
//           flip_rows (0x8). A write to one of them restarts the frame
//           position; a write to any other address is ignored.
// Throughput: one pixel per cycle unless settling or the queue is full. The
//   cell-sum memory is read when a pixel is taken and written back the
//   next cycle; a pixel that hits the cell just written gets the fresh sum
//   from a forwarding register. Result path: the result of a cell-completing
//   pixel is registered in stage 1 and stage 2, then queued and offered.
// Reset and config writes: in_tready stays low while the cell geometry
//   (last cell column/row and their partial sizes) settles.
//   The sum memory needs no clearing: each cell overwrites its entry on its
//   first pixel.
// Receiver stall: up to 4 results queue; in_tready drops once the queue and
//   the pixels in flight could fill it, and rises again as results drain.
`timescale 1ns / 1ps
`default_nettype none

module rgba_cell_average_threshold_top
  import rcat_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Pixel input
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [IN_DW-1:0]    in_tdata,   // red[7:0] green[15:8] blue[23:16] alpha[31:24]
  // Cell results
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OUT_DW-1:0]        out_tdata,  // cell_col[8:0] cell_row[17:9] color[20:18]
                                               // opaque[21], zeros above
  output logic                     out_tlast,  // row_end
  // Configuration
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [APB_AW-1:0]   cfg_paddr,
  input  wire logic [APB_DW-1:0]   cfg_pwdata,
  output logic [APB_DW-1:0]        cfg_prdata,
  output logic                     cfg_pready
);

  localparam int NCELLS = (MAX_WIDTH + CELL_W - 1) / CELL_W;
  localparam int NROWS  = (MAX_HEIGHT + CELL_H - 1) / CELL_H;
  localparam int CX_W   = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int CR_W   = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int WM_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HM_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam logic [SUB_W-1:0] SUB_MAX = SUB_W'(CELL_W - 1);
  localparam logic [RIN_W-1:0] RIN_MAX = RIN_W'(CELL_H - 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [FW_W-1:0] fw_r;
  logic [FH_W-1:0] fh_r;
  logic            flip_r;
  logic            cfg_wr;
  logic            cfg_reg_wr;
  cfg_reg_t        cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);
  // Only writes that land on a register restart the frame
  assign cfg_reg_wr = cfg_wr && ((cfg_sel == REG_FRAME_WIDTH) ||
                                 (cfg_sel == REG_FRAME_HEIGHT) ||
                                 (cfg_sel == REG_FLIP_ROWS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= FW_RESET;
      fh_r   <= FH_RESET;
      flip_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_FRAME_WIDTH:  fw_r   <= cfg_pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_r   <= cfg_pwdata[FH_W-1:0];
        REG_FLIP_ROWS:    flip_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_sel)
      REG_FRAME_WIDTH:  cfg_prdata = APB_DW'(fw_r);
      REG_FRAME_HEIGHT: cfg_prdata = APB_DW'(fh_r);
      REG_FLIP_ROWS:    cfg_prdata = APB_DW'(flip_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Derived geometry, three register stages
  // ---------------------------------------------------------------------
  logic [WM_W-1:0]  wm1_r;       // clamped width - 1
  logic [HM_W-1:0]  hm1_r;       // clamped height - 1
  logic [CX_W-1:0]  last_cx_r;
  logic [CR_W-1:0]  last_cr_r;
  logic [SUB_W-1:0] last_sub_r;
  logic [RIN_W-1:0] last_rin_r;

  always_ff @(posedge clk) begin
    // clamp to 1..MAX, minus one
    if (fw_r == '0) begin
      wm1_r <= '0;
    end else if (32'(fw_r) > 32'(MAX_WIDTH)) begin
      wm1_r <= WM_W'(MAX_WIDTH - 1);
    end else begin
      wm1_r <= WM_W'(fw_r - 1'b1);
    end
    if (fh_r == '0) begin
      hm1_r <= '0;
    end else if (32'(fh_r) > 32'(MAX_HEIGHT)) begin
      hm1_r <= HM_W'(MAX_HEIGHT - 1);
    end else begin
      hm1_r <= HM_W'(fh_r - 1'b1);
    end
    // index of the last cell column and row
    last_cx_r  <= CX_W'((32'(wm1_r) * DIV5_MUL) >> DIV5_SH);
    last_cr_r  <= CR_W'((32'(hm1_r) * DIV5_MUL) >> (DIV5_SH + 1));
    // size of the last cell minus one
    last_sub_r <= SUB_W'(32'(wm1_r) - 32'(last_cx_r) * 32'd5);
    last_rin_r <= RIN_W'(32'(hm1_r) - 32'(last_cr_r) * 32'd10);
  end

  // Hold input off while geometry settles after reset or a write
  logic [2:0] settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_reg_wr) begin
      settle_r <= 3'd4;
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Frame position
  // ---------------------------------------------------------------------
  logic [WM_W-1:0]  col_r;
  logic [SUB_W-1:0] sub_r;
  logic [CX_W-1:0]  cx_r;
  logic [CR_W-1:0]  cr_r;
  logic [RIN_W-1:0] rin_r;

  logic             in_fire;
  logic [RIN_W-1:0] rows_m1;
  logic [SUB_W-1:0] cols_m1;
  logic             row_first, row_last;
  logic             px_start, px_done, px_row_end;
  logic             frame_end;

  assign in_fire = in_tvalid && in_tready;

  always_comb begin
    rows_m1    = (cr_r == last_cr_r) ? last_rin_r : RIN_MAX;
    cols_m1    = (cx_r == last_cx_r) ? last_sub_r : SUB_MAX;
    row_first  = flip_r ? (rin_r == rows_m1) : (rin_r == '0);
    row_last   = flip_r ? (rin_r == '0) : (rin_r == rows_m1);
    px_start   = row_first && (sub_r == '0);
    px_done    = row_last && (sub_r == cols_m1);
    px_row_end = (col_r == wm1_r);
    frame_end  = flip_r ? ((cr_r == '0) && (rin_r == '0))
                        : ((cr_r == last_cr_r) && (rin_r == last_rin_r));
  end

  // Advance column, cell, display row; restart at frame start
  always_ff @(posedge clk) begin
    if (settle_r == 3'd1) begin
      col_r <= '0;
      sub_r <= '0;
      cx_r  <= '0;
      cr_r  <= flip_r ? last_cr_r : '0;
      rin_r <= flip_r ? last_rin_r : '0;
    end else if (in_fire) begin
      if (px_row_end) begin
        col_r <= '0;
        sub_r <= '0;
        cx_r  <= '0;
        if (frame_end) begin
          cr_r  <= flip_r ? last_cr_r : '0;
          rin_r <= flip_r ? last_rin_r : '0;
        end else if (flip_r) begin
          if (rin_r == '0) begin
            rin_r <= RIN_MAX;
            cr_r  <= cr_r - 1'b1;
          end else begin
            rin_r <= rin_r - 1'b1;
          end
        end else begin
          if (rin_r == RIN_MAX) begin
            rin_r <= '0;
            cr_r  <= cr_r + 1'b1;
          end else begin
            rin_r <= rin_r + 1'b1;
          end
        end
      end else begin
        col_r <= col_r + 1'b1;
        if (sub_r == SUB_MAX) begin
          sub_r <= '0;
          cx_r  <= cx_r + 1'b1;
        end else begin
          sub_r <= sub_r + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Cell-sum memory, read on accept, written back the next cycle
  // ---------------------------------------------------------------------
  sum_vec_t         cell_mem [NCELLS];
  sum_vec_t         mem_rd_r;

  logic             s1_valid_r;
  logic [CX_W-1:0]  s1_cx_r;
  logic [CR_W-1:0]  s1_cr_r;
  pix_vec_t         s1_pix_r;
  logic             s1_start_r, s1_done_r, s1_row_end_r;
  logic [RIN_W-1:0] s1_rows_m1_r;
  logic [SUB_W-1:0] s1_cols_m1_r;

  logic             fwd_valid_r;
  logic [CX_W-1:0]  fwd_cx_r;
  sum_vec_t         fwd_sum_r;

  sum_vec_t         s1_base;
  sum_vec_t         s1_sum;
  logic [CNT_W-1:0] s1_cnt;
  logic [LIM_W-1:0] s1_lim;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_rd_r <= cell_mem[cx_r];
    end
    if (s1_valid_r) begin
      cell_mem[s1_cx_r] <= s1_sum;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cx_r      <= cx_r;
      s1_cr_r      <= cr_r;
      s1_pix_r     <= pix_vec_t'(in_tdata);
      s1_start_r   <= px_start;
      s1_done_r    <= px_done;
      s1_row_end_r <= px_row_end;
      s1_rows_m1_r <= rows_m1;
      s1_cols_m1_r <= cols_m1;
    end
    fwd_cx_r  <= s1_cx_r;
    fwd_sum_r <= s1_sum;
  end

  // Take the sum just written when the same cell follows directly
  always_comb begin
    s1_base = (fwd_valid_r && (fwd_cx_r == s1_cx_r)) ? fwd_sum_r : mem_rd_r;
    for (int i = 0; i < 4; i++) begin
      s1_sum[i] = s1_start_r ? SUM_W'(s1_pix_r[i])
                             : s1_base[i] + SUM_W'(s1_pix_r[i]);
    end
    s1_cnt = CNT_W'((CNT_W'(s1_rows_m1_r) + 1'b1) * (CNT_W'(s1_cols_m1_r) + 1'b1));
    s1_lim = (LIM_W'(s1_cnt) << 7) + LIM_W'(s1_cnt);
  end

  // ---------------------------------------------------------------------
  // Stage 2: threshold compare
  // ---------------------------------------------------------------------
  logic             s2_valid_r;
  logic [CX_W-1:0]  s2_cx_r;
  logic [CR_W-1:0]  s2_cr_r;
  logic             s2_row_end_r;
  sum_vec_t         s2_sum_r;
  logic [LIM_W-1:0] s2_lim_r;
  result_t          s2_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_fire;
      s2_valid_r  <= s1_valid_r && s1_done_r;
      fwd_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_cx_r      <= s1_cx_r;
    s2_cr_r      <= s1_cr_r;
    s2_row_end_r <= s1_row_end_r;
    s2_sum_r     <= s1_sum;
    s2_lim_r     <= s1_lim;
  end

  always_comb begin
    s2_result.cell_col = COORD_W'(s2_cx_r);
    s2_result.cell_row = COORD_W'(s2_cr_r);
    for (int i = 0; i < COLOR_W; i++) begin
      s2_result.color[i] = (s2_sum_r[i] >= SUM_W'(s2_lim_r));
    end
    s2_result.opaque  = (s2_sum_r[3] >= SUM_W'(s2_lim_r));
    s2_result.row_end = s2_row_end_r;
  end

  // ---------------------------------------------------------------------
  // Result queue and input flow control
  // ---------------------------------------------------------------------
  result_t               q_data;
  logic [OUT_CNT_W-1:0]  q_count;
  logic [OUT_CNT_W-1:0]  pending;

  rcat_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_valid_r),
    .push_data (s2_result),
    .pop_ready (out_tready),
    .pop_valid (out_tvalid),
    .pop_data  (q_data),
    .count     (q_count)
  );

  assign pending   = q_count + OUT_CNT_W'(s1_valid_r && s1_done_r)
                             + OUT_CNT_W'(s2_valid_r);
  assign in_tready = (settle_r == '0) && (pending < OUT_CNT_W'(OUT_DEPTH));

  assign out_tdata = {2'b00, q_data.opaque, q_data.color, q_data.cell_row, q_data.cell_col};
  assign out_tlast = q_data.row_end;

endmodule : rgba_cell_average_threshold_top

`default_nettype wire

>>> design/rcat_checker.sv
// Port-level checker for the RGBA cell average/threshold block, bound to
// the top level. Depends on rcat_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none

module rcat_checker
  import rcat_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata,
  input wire logic              out_tlast,
  input wire logic              cfg_psel,
  input wire logic              cfg_penable,
  input wire logic              cfg_pwrite,
  input wire logic [APB_AW-1:0] cfg_paddr
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result dropped or changed");

  // Pad bits of the result stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DW-1:OUT_DW-2] == 2'b00)
    else $error("result pad bits set");

  // Reset empties the queue and blocks input
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("block active right after reset");

  // A register write pauses input while geometry settles
  a_cfg_pause: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[3:2] <= 2'(REG_FLIP_ROWS))
      |=> !in_tready ##1 !in_tready)
    else $error("pixel taken during geometry update");

endmodule : rcat_checker

bind rgba_cell_average_threshold_top rcat_checker u_rcat_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .out_tlast   (out_tlast),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr)
);

`default_nettype wire
